/* src/bpm_pkg.sv */
package bpm_pkg;

	localparam int MAX_LENGTH = 64;
	localparam int MAX_BASIS  = 16;

	localparam int COL_W   = $clog2(MAX_LENGTH);
	localparam int ROW_W   = $clog2(MAX_BASIS);
	localparam int ADDR_W  = ROW_W + COL_W;
	localparam int VAL_W   = 16;
	localparam int PROD_W  = 2 * VAL_W;
	localparam int ACC_W   = 40;
	localparam int LEN_REG_W = 7;
	localparam int CNT_REG_W = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 7;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VECTOR_LENGTH = 1'b0,
		REG_BASIS_COUNT   = 1'b1
	} bpm_reg_t;

	typedef enum logic {
		MODE_LOAD = 1'b0,
		MODE_DATA = 1'b1
	} bpm_mode_t;

	// controller -> datapath
	typedef struct packed {
		logic             load_we;
		logic             start;
		logic             issue;
		logic [ROW_W-1:0] issue_row;
		logic             emit;
		logic [ROW_W-1:0] emit_row;
		logic             emit_last;
		logic             finish;
		logic             advance;
	} bpm_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic             vec_end;
		logic [ROW_W-1:0] last_row;
		logic             out_free;
	} bpm_sts_t;

endpackage

/* src/basis_projection_mac_unit.sv */
// Load item: taken whenever the unit is idle.
// Data item: one coefficient RAM read per basis vector, then the
// multiply/accumulate stages empty before the next item is taken.
// End of vector adds basis_count projections of output, one per cycle while m_tready allows.
// Reset clears accumulators, element position and handshakes and sets the
// registers to 64 / 16; the coefficient RAM is not cleared and must be loaded.
module basis_projection_mac_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // basis_row[3:0], basis_col[9:4], value[25:10], zero
	input  logic        s_tuser,  // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // basis_index[3:0], projection[43:4], zero
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [bpm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bpm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bpm_pkg::*;

	bpm_cmd_t         cmd;
	bpm_sts_t         sts;
	logic [ROW_W-1:0] out_index;
	logic [ACC_W-1:0] out_projection;

	assign cfg_ready = 1'b1;

	bpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_mode  (s_tuser),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bpm_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_row         (s_tdata[3:0]),
		.in_col         (s_tdata[9:4]),
		.in_value       (s_tdata[25:10]),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_index      (out_index),
		.out_projection (out_projection),
		.out_last       (m_tlast)
	);

	assign m_tdata = {4'b0, out_projection, out_index};

endmodule

/* src/bpm_ram.sv */
module bpm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* src/bpm_datapath.sv */
module bpm_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bpm_pkg::bpm_cmd_t         cmd,
	output bpm_pkg::bpm_sts_t         sts,
	input  logic                      cfg_valid,
	input  logic [bpm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bpm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [bpm_pkg::ROW_W-1:0] in_row,
	input  logic [bpm_pkg::COL_W-1:0] in_col,
	input  logic [bpm_pkg::VAL_W-1:0] in_value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [bpm_pkg::ROW_W-1:0] out_index,
	output logic [bpm_pkg::ACC_W-1:0] out_projection,
	output logic                      out_last
);
	import bpm_pkg::*;

	logic [LEN_REG_W-1:0] len_reg_q;
	logic [CNT_REG_W-1:0] cnt_reg_q;
	logic [LEN_REG_W-1:0] len_eff;
	logic [CNT_REG_W-1:0] cnt_eff;
	logic [COL_W-1:0]     pos_q;
	logic [VAL_W-1:0]     value_q;
	logic [VAL_W-1:0]     coef_s1;
	logic                 valid_s1;
	logic [ROW_W-1:0]     row_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic                 valid_s2;
	logic [ROW_W-1:0]     row_s2;
	logic [ACC_W-1:0]     acc_q [MAX_BASIS];
	logic                 out_valid_q;
	logic [ROW_W-1:0]     out_index_q;
	logic [ACC_W-1:0]     out_proj_q;
	logic                 out_last_q;

	// config registers; the user must write them only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_reg_q <= LEN_REG_W'(MAX_LENGTH);
			cnt_reg_q <= CNT_REG_W'(MAX_BASIS);
		end else if (cfg_valid) begin
			unique case (bpm_reg_t'(cfg_index))
				REG_VECTOR_LENGTH: len_reg_q <= cfg_data[LEN_REG_W-1:0];
				REG_BASIS_COUNT:   cnt_reg_q <= cfg_data[CNT_REG_W-1:0];
				default:           ;
			endcase
		end
	end

	always_comb begin
		priority if (len_reg_q == '0) begin
			len_eff = LEN_REG_W'(1);
		end else if (len_reg_q > LEN_REG_W'(MAX_LENGTH)) begin
			len_eff = LEN_REG_W'(MAX_LENGTH);
		end else begin
			len_eff = len_reg_q;
		end
		priority if (cnt_reg_q == '0) begin
			cnt_eff = CNT_REG_W'(1);
		end else if (cnt_reg_q > CNT_REG_W'(MAX_BASIS)) begin
			cnt_eff = CNT_REG_W'(MAX_BASIS);
		end else begin
			cnt_eff = cnt_reg_q;
		end
	end

	assign sts.vec_end  = (LEN_REG_W'(pos_q) + LEN_REG_W'(1)) >= len_eff;
	assign sts.last_row = ROW_W'(cnt_eff - CNT_REG_W'(1));
	assign sts.out_free = !out_valid_q || out_ready;

	bpm_ram #(
		.WIDTH(VAL_W),
		.DEPTH(MAX_BASIS * MAX_LENGTH)
	) u_basis_ram (
		.clk   (clk),
		.we    (cmd.load_we),
		.waddr ({in_row, in_col}),
		.wdata (in_value),
		.raddr ({cmd.issue_row, pos_q}),
		.rdata (coef_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.finish) begin
			pos_q <= '0;
		end else if (cmd.advance) begin
			pos_q <= pos_q + COL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			value_q <= in_value;
		end
		row_s1  <= cmd.issue_row;
		row_s2  <= row_s1;
		prod_s2 <= $signed(coef_s1) * $signed(value_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_BASIS; i++) begin
				acc_q[i] <= '0;
			end
		end else if (cmd.finish) begin
			for (int i = 0; i < MAX_BASIS; i++) begin
				acc_q[i] <= '0;
			end
		end else if (valid_s2) begin
			acc_q[row_s2] <= acc_q[row_s2] + ACC_W'(prod_s2);
		end
	end

	// output register; emit is only issued when sts.out_free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_index_q <= cmd.emit_row;
			out_proj_q  <= acc_q[cmd.emit_row];
			out_last_q  <= cmd.emit_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_index      = out_index_q;
	assign out_projection = out_proj_q;
	assign out_last       = out_last_q;

endmodule

/* src/bpm_ctrl.sv */
module bpm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_mode,
	output logic              in_ready,
	input  bpm_pkg::bpm_sts_t sts,
	output bpm_pkg::bpm_cmd_t cmd
);
	import bpm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic [ROW_W-1:0] row_q;
	logic [ROW_W-1:0] last_q;
	logic             end_q;
	logic             drain_q;
	logic             accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd           = '0;
		cmd.load_we   = accept && (bpm_mode_t'(in_mode) == MODE_LOAD);
		cmd.start     = accept && (bpm_mode_t'(in_mode) == MODE_DATA);
		cmd.issue     = (state_q == ST_MAC);
		cmd.issue_row = row_q;
		cmd.emit      = (state_q == ST_EMIT) && sts.out_free;
		cmd.emit_row  = row_q;
		cmd.emit_last = (row_q == last_q);
		cmd.finish    = cmd.emit && cmd.emit_last;
		cmd.advance   = (state_q == ST_DRAIN) && drain_q && !end_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			last_q  <= '0;
			end_q   <= 1'b0;
			drain_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						end_q   <= sts.vec_end;
						last_q  <= sts.last_row;
						row_q   <= '0;
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (row_q == last_q) begin
						drain_q <= 1'b0;
						state_q <= ST_DRAIN;
					end else begin
						row_q <= row_q + ROW_W'(1);
					end
				end
				// wait for the read/multiply/accumulate stages to empty
				ST_DRAIN: begin
					if (drain_q) begin
						row_q   <= '0;
						state_q <= end_q ? ST_EMIT : ST_IDLE;
					end
					drain_q <= !drain_q;
				end
				ST_EMIT: begin
					if (cmd.emit) begin
						if (cmd.emit_last) begin
							state_q <= ST_IDLE;
						end else begin
							row_q <= row_q + ROW_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
